@@ rtl/edf_pkg.sv @@
// Package for the earliest-deadline-first task scheduler.
// Holds field widths, default parameter values and operation and record codes.
// No dependencies.
package edf_pkg;

  localparam int DEF_TABLE_SLOTS = 16;
  localparam int DEF_TIME_BITS   = 16;

  localparam int ID_BITS       = 8;
  localparam int SVC_BITS      = 16;
  localparam int DL_BITS       = 16;
  localparam int OUT_TIME_BITS = 16;

  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic KIND_DONE   = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

endpackage

@@ rtl/edf_task_scheduler.sv @@
// Top level of the earliest-deadline-first task scheduler.
// Keeps the task table in one synchronous memory and valid bits in flip-flops.
// Depends on edf_pkg.
//
// Usage:
// The input channel (in_valid, in_stall) carries one transaction per item:
// an arrival (operation = OP_ARRIVAL) with task_id, service_time and
// relative_deadline, or a tick (operation = OP_TICK). The output channel
// (out_valid, out_stall) carries completion records and rejections.
// An arrival writes a free slot in the arrival step or, with the table full,
// loads a rejection into the output register. A tick reads one table slot per
// cycle through the single memory read port in the scan, then a completion
// record for a finished task is loaded in the finish step. One item is
// processed at a time; in_stall is high while an item is in progress.
// A result waits in the output register while out_stall is high. The next
// item is still accepted; only an item that must emit a result of its own
// holds in its last step until the output register is free.
// Reset empties the table and clears the time; no clearing pass is needed.
module edf_task_scheduler #(
  parameter int TABLE_SLOTS = edf_pkg::DEF_TABLE_SLOTS,
  parameter int TIME_BITS   = edf_pkg::DEF_TIME_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               operation,
  input  logic [edf_pkg::ID_BITS-1:0]        task_id,
  input  logic [edf_pkg::SVC_BITS-1:0]       service_time,
  input  logic [edf_pkg::DL_BITS-1:0]        relative_deadline,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               record_kind,
  output logic [edf_pkg::ID_BITS-1:0]        done_id,
  output logic [edf_pkg::OUT_TIME_BITS-1:0]  wait_time,
  output logic [edf_pkg::OUT_TIME_BITS-1:0]  turnaround_time,
  output logic                               deadline_met
);

  localparam int SLOT_BITS = $clog2(TABLE_SLOTS);
  localparam int EXT_BITS  = (TIME_BITS > edf_pkg::OUT_TIME_BITS) ?
                             TIME_BITS : edf_pkg::OUT_TIME_BITS;
  localparam int ABS_BITS  = EXT_BITS + 1;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_ARRIVE   = 3'd1;
  localparam logic [2:0] ST_SCAN     = 3'd2;
  localparam logic [2:0] ST_SCAN_END = 3'd3;
  localparam logic [2:0] ST_FINISH   = 3'd4;

  typedef struct packed {
    logic [edf_pkg::ID_BITS-1:0]  task_id;
    logic [TIME_BITS-1:0]         arrival;
    logic [ABS_BITS-1:0]          abs_deadline;
    logic [edf_pkg::DL_BITS-1:0]  rel_deadline;
    logic [edf_pkg::SVC_BITS-1:0] remaining;
    logic [TIME_BITS-1:0]         start;
    logic                         started;
  } slot_rec_t;

  slot_rec_t mem [TABLE_SLOTS];

  logic [2:0]                   state;
  logic [TABLE_SLOTS-1:0]       slot_valid;
  logic [TIME_BITS-1:0]         cur_time;
  logic [SLOT_BITS-1:0]         scan_idx;
  logic [SLOT_BITS-1:0]         rd_idx;
  logic                         rd_pending;
  slot_rec_t                    rd_data;
  slot_rec_t                    best;
  logic [SLOT_BITS-1:0]         best_idx;
  logic                         best_found;

  logic [edf_pkg::ID_BITS-1:0]  id_q;
  logic [edf_pkg::SVC_BITS-1:0] svc_q;
  logic [edf_pkg::DL_BITS-1:0]  rel_q;

  logic                         in_accept;
  logic                         out_free;
  logic                         res_load;
  logic                         any_free;
  logic [SLOT_BITS-1:0]         free_idx;
  logic                         mem_we;
  logic [SLOT_BITS-1:0]         mem_waddr;
  slot_rec_t                    mem_wdata;
  slot_rec_t                    arr_rec;
  slot_rec_t                    upd_rec;
  logic [TIME_BITS-1:0]         cur_plus;
  logic [TIME_BITS-1:0]         fin_start;
  logic                         fin_done;
  logic [TIME_BITS-1:0]         wait_t;
  logic [TIME_BITS-1:0]         turn_t;
  logic [EXT_BITS-1:0]          wait_ext;
  logic [EXT_BITS-1:0]          turn_ext;
  logic                         cand_better;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign res_load  = out_free && ((state == ST_ARRIVE && !any_free) ||
                                  (state == ST_FINISH && best_found && fin_done));

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        any_free = 1'b1;
        free_idx = SLOT_BITS'(i);
      end
    end
  end

  always_comb begin
    arr_rec              = '0;
    arr_rec.task_id      = id_q;
    arr_rec.arrival      = cur_time;
    arr_rec.abs_deadline = ABS_BITS'(cur_time) + ABS_BITS'(rel_q);
    arr_rec.rel_deadline = rel_q;
    arr_rec.remaining    = (svc_q == '0) ? edf_pkg::SVC_BITS'(1) : svc_q;
    arr_rec.start        = '0;
    arr_rec.started      = 1'b0;
  end

  assign cur_plus  = cur_time + TIME_BITS'(1);
  assign fin_start = best.started ? best.start : cur_time;
  assign fin_done  = (best.remaining <= edf_pkg::SVC_BITS'(1));
  assign wait_t    = fin_start - best.arrival;
  assign turn_t    = cur_plus - best.arrival;
  assign wait_ext  = EXT_BITS'(wait_t);
  assign turn_ext  = EXT_BITS'(turn_t);

  always_comb begin
    upd_rec           = best;
    upd_rec.started   = 1'b1;
    upd_rec.start     = fin_start;
    upd_rec.remaining = best.remaining - edf_pkg::SVC_BITS'(1);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = free_idx;
    mem_wdata = arr_rec;
    if (state == ST_ARRIVE && any_free) begin
      mem_we = 1'b1;
    end else if (state == ST_FINISH && best_found && !fin_done) begin
      mem_we    = 1'b1;
      mem_waddr = best_idx;
      mem_wdata = upd_rec;
    end
  end

  assign cand_better = rd_pending && slot_valid[rd_idx] &&
                       (!best_found || (rd_data.abs_deadline < best.abs_deadline));

  // Writes happen only in the arrival and finish steps and reads only during
  // the scan, so the same entry is never read and written in overlapping cycles.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      rd_data <= mem[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      id_q  <= task_id;
      svc_q <= service_time;
      rel_q <= relative_deadline;
    end
    if (state == ST_SCAN) begin
      rd_idx <= scan_idx;
    end
    if (cand_better) begin
      best     <= rd_data;
      best_idx <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      cur_time   <= '0;
      scan_idx   <= '0;
      rd_pending <= 1'b0;
      best_found <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      rd_pending <= (state == ST_SCAN);
      if (cand_better) begin
        best_found <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (operation == edf_pkg::OP_ARRIVAL) begin
              state <= ST_ARRIVE;
            end else begin
              state      <= ST_SCAN;
              scan_idx   <= '0;
              best_found <= 1'b0;
            end
          end
        end
        ST_ARRIVE: begin
          if (any_free) begin
            slot_valid[free_idx] <= 1'b1;
            state                <= ST_IDLE;
          end else if (out_free) begin
            record_kind     <= edf_pkg::KIND_REJECT;
            done_id         <= id_q;
            wait_time       <= '0;
            turnaround_time <= '0;
            deadline_met    <= 1'b0;
            state           <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          scan_idx <= scan_idx + SLOT_BITS'(1);
          if (scan_idx == SLOT_BITS'(TABLE_SLOTS - 1)) begin
            state <= ST_SCAN_END;
          end
        end
        ST_SCAN_END: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!best_found || !fin_done) begin
            cur_time <= cur_plus;
            state    <= ST_IDLE;
          end else if (out_free) begin
            cur_time             <= cur_plus;
            slot_valid[best_idx] <= 1'b0;
            record_kind          <= edf_pkg::KIND_DONE;
            done_id              <= best.task_id;
            wait_time            <= wait_ext[edf_pkg::OUT_TIME_BITS-1:0];
            turnaround_time      <= turn_ext[edf_pkg::OUT_TIME_BITS-1:0];
            deadline_met         <= (turn_ext <= EXT_BITS'(best.rel_deadline));
            state                <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state != ST_IDLE))
    else $error("Accepted transaction did not start processing.");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_ARRIVE || state == ST_FINISH))
    else $error("Result appeared outside the arrival or finish step.");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_SCAN_END) |-> !mem_we)
    else $error("Table write during a deadline scan.");

  a_time_holds_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |=> $stable(cur_time))
    else $error("Current time changed during a deadline scan.");

endmodule

@@ tb/sv/edf_task_scheduler_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the earliest-deadline-first task scheduler.
// Predicts every completion and rejection record from its own copy of the task table.
// Depends on edf_pkg and edf_task_scheduler.
module edf_task_scheduler_test;
  import edf_pkg::*;

  localparam int TABLE_SLOTS = DEF_TABLE_SLOTS;
  localparam int TIME_BITS   = DEF_TIME_BITS;
  localparam int RANDOM_ITEMS = 1650;

  typedef struct packed {
    logic                     kind;
    logic [ID_BITS-1:0]       id;
    logic [OUT_TIME_BITS-1:0] waited;
    logic [OUT_TIME_BITS-1:0] turnaround;
    logic                     met;
  } sched_record_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic operation;
  logic [ID_BITS-1:0] task_id;
  logic [SVC_BITS-1:0] service_time;
  logic [DL_BITS-1:0] relative_deadline;
  logic out_valid;
  logic out_stall = 1'b0;
  logic record_kind;
  logic [ID_BITS-1:0] done_id;
  logic [OUT_TIME_BITS-1:0] wait_time;
  logic [OUT_TIME_BITS-1:0] turnaround_time;
  logic deadline_met;

  logic [TIME_BITS-1:0] sched_now;
  logic                 slot_busy [TABLE_SLOTS];
  logic                 slot_begun [TABLE_SLOTS];
  logic [ID_BITS-1:0]   slot_owner [TABLE_SLOTS];
  logic [TIME_BITS-1:0] slot_arrival [TABLE_SLOTS];
  logic [TIME_BITS:0]   slot_due [TABLE_SLOTS];
  logic [DL_BITS-1:0]   slot_rel [TABLE_SLOTS];
  logic [SVC_BITS-1:0]  slot_left [TABLE_SLOTS];
  logic [TIME_BITS-1:0] slot_first_run [TABLE_SLOTS];

  sched_record_t pending_records[$];
  sched_record_t got_rec;
  int mismatches = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  int stall_run = 0;
  int stall_roll;

  edf_task_scheduler #(.TABLE_SLOTS(TABLE_SLOTS), .TIME_BITS(TIME_BITS)) uut (.*);

  always #6 clk = ~clk;

  function automatic void admit_task(input logic [ID_BITS-1:0] id,
                                     input logic [SVC_BITS-1:0] svc,
                                     input logic [DL_BITS-1:0] rel);
    sched_record_t rec;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (!slot_busy[i]) begin
        slot_busy[i] = 1'b1;
        slot_begun[i] = 1'b0;
        slot_owner[i] = id;
        slot_arrival[i] = sched_now;
        slot_rel[i] = rel;
        slot_due[i] = (TIME_BITS+1)'(sched_now) + (TIME_BITS+1)'(rel);
        slot_left[i] = (svc == '0) ? SVC_BITS'(1) : svc;
        slot_first_run[i] = '0;
        return;
      end
    end
    rec = '0;
    rec.kind = KIND_REJECT;
    rec.id = id;
    pending_records.push_back(rec);
  endfunction

  function automatic void run_one_tick();
    int pick;
    logic [TIME_BITS-1:0] waited, turned;
    sched_record_t rec;
    pick = -1;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (slot_busy[i] && (pick < 0 || slot_due[i] < slot_due[pick])) pick = i;
    end
    if (pick < 0) begin
      sched_now = sched_now + 1'b1;
      return;
    end
    if (!slot_begun[pick]) begin
      slot_begun[pick] = 1'b1;
      slot_first_run[pick] = sched_now;
    end
    if (slot_left[pick] != '0) slot_left[pick] = slot_left[pick] - 1'b1;
    sched_now = sched_now + 1'b1;
    if (slot_left[pick] != '0) return;
    waited = slot_first_run[pick] - slot_arrival[pick];
    turned = sched_now - slot_arrival[pick];
    rec.kind = KIND_DONE;
    rec.id = slot_owner[pick];
    rec.waited = OUT_TIME_BITS'(waited);
    rec.turnaround = OUT_TIME_BITS'(turned);
    rec.met = (turned <= slot_rel[pick]);
    pending_records.push_back(rec);
    slot_busy[pick] = 1'b0;
    slot_begun[pick] = 1'b0;
  endfunction

  function automatic bit table_has_tasks();
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (slot_busy[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int sender_gap();
    int roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(input string field, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_item(input logic op, input logic [ID_BITS-1:0] id,
                           input logic [SVC_BITS-1:0] svc, input logic [DL_BITS-1:0] rel);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    task_id <= id;
    service_time <= svc;
    relative_deadline <= rel;
    do @(posedge clk); while (in_stall);
    if (op == OP_ARRIVAL) admit_task(id, svc, rel);
    else run_one_tick();
  endtask

  task automatic send_arrival(input logic [ID_BITS-1:0] id, input logic [SVC_BITS-1:0] svc,
                              input logic [DL_BITS-1:0] rel);
    send_item(OP_ARRIVAL, id, svc, rel);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, ID_BITS'($urandom), SVC_BITS'($urandom), DL_BITS'($urandom));
  endtask

  task automatic run_until_empty();
    while (table_has_tasks()) send_tick();
  endtask

  task automatic wait_for_records();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_records.size() != 0);
  endtask

  task automatic test_edge_values();
    send_item(OP_TICK, '1, '1, '1);
    send_arrival(8'h00, 16'h0000, 16'h0000);
    send_tick();
    send_arrival(8'hFF, 16'h0001, 16'hFFFF);
    send_tick();
    send_arrival(8'h05, 16'h0002, 16'h0001);
    send_arrival(8'h06, 16'h0002, 16'h0002);
    run_until_empty();
    send_item(OP_TICK, '0, '0, '0);
    wait_for_records();
  endtask

  task automatic test_deadline_order();
    send_arrival(8'h21, 16'd3, 16'd50);
    send_arrival(8'h22, 16'd2, 16'd10);
    send_arrival(8'h23, 16'd1, 16'd10);
    send_tick();
    send_arrival(8'h24, 16'd1, 16'd0);
    run_until_empty();
    send_arrival(8'h31, 16'd5, 16'd40);
    send_arrival(8'h32, 16'd5, 16'd30);
    repeat (6) send_tick();
    send_arrival(8'h33, 16'd1, 16'd35);
    run_until_empty();
    wait_for_records();
  endtask

  task automatic test_table_full();
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      send_arrival(ID_BITS'(8'h40 + i), SVC_BITS'(1 + i % 3), DL_BITS'(3 * i));
    end
    send_arrival(8'h7E, 16'd5, 16'd9);
    send_arrival(8'h81, 16'd1, 16'hFFFF);
    send_tick();
    send_arrival(8'h99, 16'd2, 16'd4);
    send_arrival(8'hA0, 16'd2, 16'd4);
    run_until_empty();
    wait_for_records();
  endtask

  task automatic test_random_mix();
    int sent, burst, arrive_pct, roll;
    logic [SVC_BITS-1:0] svc;
    logic [DL_BITS-1:0] rel;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 2);
      arrive_pct = (roll == 0) ? 25 : (roll == 1) ? 50 : 75;
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      burst = $urandom_range(20, 80);
      repeat (burst) begin
        if ($urandom_range(0, 99) < arrive_pct) begin
          roll = $urandom_range(0, 99);
          if (roll < 5) svc = '0;
          else if (roll < 80) svc = SVC_BITS'($urandom_range(1, 4));
          else svc = SVC_BITS'($urandom_range(5, 40));
          if ($urandom_range(0, 1) == 0) rel = DL_BITS'($urandom_range(0, 24));
          else rel = DL_BITS'($urandom);
          send_arrival(ID_BITS'($urandom), svc, rel);
        end else begin
          send_tick();
        end
        sent++;
      end
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    run_until_empty();
    wait_for_records();
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_records.size() == 0) begin
        $error("unexpected record: kind %0d, id %0d", record_kind, done_id);
        mismatches++;
      end else begin
        got_rec = pending_records.pop_front();
        check_field("record_kind", 16'(got_rec.kind), 16'(record_kind));
        check_field("done_id", 16'(got_rec.id), 16'(done_id));
        check_field("wait_time", got_rec.waited, wait_time);
        check_field("turnaround_time", got_rec.turnaround, turnaround_time);
        check_field("deadline_met", 16'(got_rec.met), 16'(deadline_met));
      end
    end
    if (stall_run > 0) begin
      stall_run = stall_run - 1;
      out_stall <= 1'b1;
    end else if (!stalls_on) begin
      out_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 3) begin
        stall_run = $urandom_range(8, 40);
        out_stall <= 1'b1;
      end else if (stall_roll < 25) begin
        stall_run = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_ARRIVAL;
    task_id = '0;
    service_time = '0;
    relative_deadline = '0;
    sched_now = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_begun[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_edge_values();
    test_deadline_order();
    test_table_full();
    test_random_mix();
    repeat (2 * (TABLE_SLOTS + 3)) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
